@@ rtl/core/mcra_pkg.sv @@
// Shared types and constants of the minima-controlled noise estimator.
package mcra_pkg;

    localparam int MAG_W  = 24;
    localparam int PROB_W = 14;
    localparam int BIN_W  = 10;
    localparam int CNT_W  = 8;
    localparam int CFG_W  = 10;
    localparam int IDX_W  = 2;

    // Configuration register indexes
    localparam logic [IDX_W-1:0] CFG_LAST_BIN_INDEX     = 2'd0;
    localparam logic [IDX_W-1:0] CFG_LONG_WINDOW_FRAMES = 2'd1;
    localparam logic [IDX_W-1:0] CFG_STARTUP_FRAMES     = 2'd2;

    localparam logic [BIN_W-1:0] LAST_BIN_INDEX_RST     = 10'd256;
    localparam logic [CNT_W-1:0] LONG_WINDOW_FRAMES_RST = 8'd50;
    localparam logic [CNT_W-1:0] STARTUP_FRAMES_RST     = 8'd10;

    // Three quarters of unity presence in Q14
    localparam logic [PROB_W-1:0] PRESENCE_STEP = 14'd12288;
    localparam int                PROB_SHIFT    = 14;

    typedef struct packed {
        logic [MAG_W-1:0]  smoothed;
        logic [MAG_W-1:0]  local_min;
        logic [MAG_W-1:0]  running_min;
        logic [PROB_W-1:0] presence;
        logic [MAG_W-1:0]  noise;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic             first;
        logic             swap;
        logic             last;
        logic [BIN_W-1:0] bin;
    } item_ctl_t;

    typedef struct packed {
        logic [MAG_W-1:0]  noise;
        logic [PROB_W-1:0] presence;
        logic [BIN_W-1:0]  bin;
        logic              last;
    } result_t;

endpackage

@@ rtl/core/mcra_if.sv @@
// Valid/ready channel interfaces for spectral bins in and noise results out.
interface mcra_in_if;
    logic                       valid;
    logic                       ready;
    logic [mcra_pkg::MAG_W-1:0] magnitude;

    modport source (output valid, output magnitude, input ready);
    modport sink (input valid, input magnitude, output ready);
endinterface

interface mcra_out_if;
    logic                        valid;
    logic                        ready;
    logic [mcra_pkg::MAG_W-1:0]  noise_estimate;
    logic [mcra_pkg::PROB_W-1:0] presence_prob;
    logic [mcra_pkg::BIN_W-1:0]  bin_index;
    logic                        last_bin;

    modport source (output valid, output noise_estimate, output presence_prob,
                    output bin_index, output last_bin, input ready);
    modport sink (input valid, input noise_estimate, input presence_prob,
                  input bin_index, input last_bin, output ready);
endinterface

@@ rtl/core/mcra_ram.sv @@
// Generic simple dual-port RAM with registered read data.
module mcra_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read-first: a read at a written address returns the old word
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ rtl/core/mcra_frame_ctrl.sv @@
// Configuration registers, bin and frame counters, and per-bin control flags.
module mcra_frame_ctrl #(
    parameter int MAX_BINS = 1024,
    localparam int AW      = $clog2(MAX_BINS)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [mcra_pkg::IDX_W-1:0]    cfg_index,
    input  logic [mcra_pkg::CFG_W-1:0]    cfg_data,
    input  logic                          accept,
    output mcra_pkg::item_ctl_t           ctl,
    output logic [AW-1:0]                 addr
);

    localparam logic [AW-1:0] ADDR_LAST = AW'(MAX_BINS - 1);

    logic [mcra_pkg::BIN_W-1:0] last_bin_index_reg, last_bin_index_next;
    logic [mcra_pkg::CNT_W-1:0] long_window_reg, long_window_next;
    logic [mcra_pkg::CNT_W-1:0] startup_reg, startup_next;
    logic [mcra_pkg::CNT_W-1:0] frame_cnt_reg, frame_cnt_next;
    logic [mcra_pkg::CNT_W-1:0] window_phase_reg, window_phase_next;
    logic [mcra_pkg::BIN_W-1:0] bin_cnt_reg, bin_cnt_next;
    logic [AW-1:0]              addr_cnt_reg, addr_cnt_next;

    logic                       startup;
    logic [mcra_pkg::CNT_W:0]   phase_inc;
    logic                       window_end;

    always_comb
    begin
        startup    = frame_cnt_reg < startup_reg;
        phase_inc  = {1'b0, window_phase_reg} + 9'd1;
        window_end = phase_inc >= {1'b0, long_window_reg};

        ctl.first = startup && (frame_cnt_reg == '0);
        ctl.swap  = startup || window_end;
        ctl.last  = bin_cnt_reg >= last_bin_index_reg;
        ctl.bin   = bin_cnt_reg;
        addr      = addr_cnt_reg;
    end

    always_comb
    begin
        last_bin_index_next = last_bin_index_reg;
        long_window_next    = long_window_reg;
        startup_next        = startup_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                mcra_pkg::CFG_LAST_BIN_INDEX:     last_bin_index_next = cfg_data;
                mcra_pkg::CFG_LONG_WINDOW_FRAMES: long_window_next    = cfg_data[7:0];
                mcra_pkg::CFG_STARTUP_FRAMES:     startup_next        = cfg_data[7:0];
                default:                          ;
            endcase
        end
    end

    always_comb
    begin
        frame_cnt_next    = frame_cnt_reg;
        window_phase_next = window_phase_reg;
        bin_cnt_next      = bin_cnt_reg;
        addr_cnt_next     = addr_cnt_reg;
        if (accept)
        begin
            if (ctl.last)
            begin
                // Close the frame
                bin_cnt_next  = '0;
                addr_cnt_next = '0;
                if (startup)
                begin
                    frame_cnt_next = frame_cnt_reg + 8'd1;
                end
                window_phase_next = window_end ? '0 : phase_inc[mcra_pkg::CNT_W-1:0];
            end
            else
            begin
                bin_cnt_next  = bin_cnt_reg + 10'd1;
                addr_cnt_next = (addr_cnt_reg == ADDR_LAST) ? '0 : addr_cnt_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_bin_index_reg <= mcra_pkg::LAST_BIN_INDEX_RST;
            long_window_reg    <= mcra_pkg::LONG_WINDOW_FRAMES_RST;
            startup_reg        <= mcra_pkg::STARTUP_FRAMES_RST;
            frame_cnt_reg      <= '0;
            window_phase_reg   <= '0;
            bin_cnt_reg        <= '0;
            addr_cnt_reg       <= '0;
        end
        else
        begin
            last_bin_index_reg <= last_bin_index_next;
            long_window_reg    <= long_window_next;
            startup_reg        <= startup_next;
            frame_cnt_reg      <= frame_cnt_next;
            window_phase_reg   <= window_phase_next;
            bin_cnt_reg        <= bin_cnt_next;
            addr_cnt_reg       <= addr_cnt_next;
        end
    end

    a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
        accept && ctl.last |=> bin_cnt_reg == '0 && addr_cnt_reg == '0)
        else $error("bin counters did not restart after the last bin of a frame");

endmodule

@@ rtl/core/mcra_update_pipe.sv @@
// Read-modify-write pipeline over the per-bin store: smoothing, minima, presence, noise.
module mcra_update_pipe #(
    parameter int MAX_BINS = 1024,
    localparam int AW      = $clog2(MAX_BINS)
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       advance,
    input  logic                       accept,
    input  mcra_pkg::item_ctl_t        ctl_in,
    input  logic [AW-1:0]              addr_in,
    input  logic [mcra_pkg::MAG_W-1:0] magnitude,
    output logic                       addr_busy,
    output logic                       push,
    output mcra_pkg::result_t          result
);

    localparam int MW = mcra_pkg::MAG_W;
    localparam int PW = mcra_pkg::PROB_W;
    localparam int BW = mcra_pkg::BIN_W;

    mcra_pkg::entry_t rd_data;
    mcra_pkg::entry_t wr_data;
    logic             wr_en;

    // Stage 1: store word arriving from the RAM
    logic                s1_valid_reg;
    mcra_pkg::item_ctl_t s1_ctl_reg;
    logic [AW-1:0]       s1_addr_reg;
    logic [MW-1:0]       s1_mag_reg;

    // Stage 2: updated store fields, multiplier operands
    logic                s2_valid_reg;
    logic [AW-1:0]       s2_addr_reg;
    logic [BW-1:0]       s2_bin_reg;
    logic                s2_last_reg;
    logic [MW-1:0]       s2_smoothed_reg;
    logic [MW-1:0]       s2_local_reg;
    logic [MW-1:0]       s2_running_reg;
    logic [PW-1:0]       s2_presence_reg;
    logic [MW-1:0]       s2_blend_reg;
    logic signed [MW:0]  s2_diff_reg;

    // Stage 3: product, final noise and write-back
    logic                s3_valid_reg;
    logic [AW-1:0]       s3_addr_reg;
    logic [BW-1:0]       s3_bin_reg;
    logic                s3_last_reg;
    logic [MW-1:0]       s3_smoothed_reg;
    logic [MW-1:0]       s3_local_reg;
    logic [MW-1:0]       s3_running_reg;
    logic [PW-1:0]       s3_presence_reg;
    logic [MW-1:0]       s3_blend_reg;
    logic signed [MW+PW+1:0] s3_prod_reg;

    mcra_ram #(
        .WIDTH (mcra_pkg::ENTRY_W),
        .DEPTH (MAX_BINS)
    ) u_store (
        .clk   (clk),
        .we    (wr_en),
        .waddr (s3_addr_reg),
        .wdata (wr_data),
        .re    (accept),
        .raddr (addr_in),
        .rdata (rd_data)
    );

    // Hold off a bin whose entry is still in flight
    assign addr_busy = (s1_valid_reg && (s1_addr_reg == addr_in))
                    || (s2_valid_reg && (s2_addr_reg == addr_in))
                    || (s3_valid_reg && (s3_addr_reg == addr_in));

    mcra_pkg::entry_t    cur;
    logic [MW-1:0]       sm;
    logic [MW-1:0]       lm;
    logic [MW-1:0]       rm;
    logic [MW-1:0]       s_new;
    logic [MW-1:0]       lm_new;
    logic [MW-1:0]       rm_new;
    logic [MW+1:0]       lm_wide;
    logic [MW+1:0]       thr;
    logic                speech;
    logic [PW-1:0]       p_new;
    logic [MW-1:0]       blend;
    logic signed [MW:0]  diff;

    always_comb
    begin
        // First frame loads the entry from the magnitude
        if (s1_ctl_reg.first)
        begin
            cur = '{smoothed: s1_mag_reg, local_min: s1_mag_reg, running_min: s1_mag_reg,
                    presence: '0, noise: s1_mag_reg};
        end
        else
        begin
            cur = rd_data;
        end

        sm = cur.smoothed;
        lm = cur.local_min;
        rm = cur.running_min;
        if (s1_ctl_reg.swap)
        begin
            lm = (rm < sm) ? rm : sm;
            rm = sm;
        end

        s_new = (sm >> 1) + (sm >> 2) + (sm >> 4) + (s1_mag_reg >> 3) + (s1_mag_reg >> 4);
        lm_new = (lm < s_new) ? lm : s_new;
        rm_new = (rm < s_new) ? rm : s_new;

        // 2.25 times the local minimum
        lm_wide = {2'b00, lm_new};
        thr     = (lm_wide >> 2) + (lm_wide << 1);
        speech  = {2'b00, s_new} > thr;
        p_new   = (cur.presence >> 2) + (speech ? mcra_pkg::PRESENCE_STEP : '0);

        blend = (cur.noise >> 1) + (cur.noise >> 2) + (cur.noise >> 3) + (cur.noise >> 4)
              + (s1_mag_reg >> 4);
        diff  = $signed({1'b0, cur.noise}) - $signed({1'b0, blend});
    end

    logic signed [PW:0]       p_signed;
    logic signed [MW+PW+1:0]  prod;

    always_comb
    begin
        p_signed = $signed({1'b0, s2_presence_reg});
        prod     = s2_diff_reg * p_signed;
    end

    logic signed [MW+PW+1:0] n_sum;
    logic [MW-1:0]           n_new;

    always_comb
    begin
        n_sum = $signed({{(PW+2){1'b0}}, s3_blend_reg}) + (s3_prod_reg >>> mcra_pkg::PROB_SHIFT);
        n_new = n_sum[MW-1:0];

        wr_en   = s3_valid_reg && advance;
        wr_data = '{smoothed: s3_smoothed_reg, local_min: s3_local_reg,
                    running_min: s3_running_reg, presence: s3_presence_reg, noise: n_new};

        push            = wr_en;
        result.noise    = n_new;
        result.presence = s3_presence_reg;
        result.bin      = s3_bin_reg;
        result.last     = s3_last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_ctl_reg      <= ctl_in;
            s1_addr_reg     <= addr_in;
            s1_mag_reg      <= magnitude;

            s2_addr_reg     <= s1_addr_reg;
            s2_bin_reg      <= s1_ctl_reg.bin;
            s2_last_reg     <= s1_ctl_reg.last;
            s2_smoothed_reg <= s_new;
            s2_local_reg    <= lm_new;
            s2_running_reg  <= rm_new;
            s2_presence_reg <= p_new;
            s2_blend_reg    <= blend;
            s2_diff_reg     <= diff;

            s3_addr_reg     <= s2_addr_reg;
            s3_bin_reg      <= s2_bin_reg;
            s3_last_reg     <= s2_last_reg;
            s3_smoothed_reg <= s2_smoothed_reg;
            s3_local_reg    <= s2_local_reg;
            s3_running_reg  <= s2_running_reg;
            s3_presence_reg <= s2_presence_reg;
            s3_blend_reg    <= s2_blend_reg;
            s3_prod_reg     <= prod;
        end
    end

    a_no_alias_s1_s2: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s2_valid_reg |-> s1_addr_reg != s2_addr_reg)
        else $error("two bins in flight share a store entry");

    a_no_alias_s1_s3: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s3_valid_reg |-> s1_addr_reg != s3_addr_reg)
        else $error("bin read before the write-back of its entry");

endmodule

@@ rtl/core/mcra_out_buf.sv @@
// Two-entry result buffer that decouples the pipeline from the output channel.
module mcra_out_buf (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  mcra_pkg::result_t result,
    output logic              room,
    mcra_out_if.source        estimate
);

    mcra_pkg::result_t slots_reg [2];
    logic [1:0]        count_reg, count_next;
    logic              wr_ptr_reg, wr_ptr_next;
    logic              rd_ptr_reg, rd_ptr_next;
    logic              pop;
    mcra_pkg::result_t head;

    always_comb
    begin
        head                    = slots_reg[rd_ptr_reg];
        room                    = count_reg != 2'd2;
        estimate.valid          = count_reg != 2'd0;
        estimate.noise_estimate = head.noise;
        estimate.presence_prob  = head.presence;
        estimate.bin_index      = head.bin;
        estimate.last_bin       = head.last;
        pop                     = estimate.valid && estimate.ready;

        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= result;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == 2'd2 |-> !push)
        else $error("result arrived while the output buffer was full");

endmodule

@@ rtl/core/mcra_noise_estimator_top.sv @@
// Top level: one spectral bin in, updated noise estimate and presence out.
// A result is presented once its bin has passed the update stages and the output buffer.
// Throughput: one bin per cycle while the output buffer has room; a bin whose
// store entry is still in the 3-stage update pipeline waits for its write-back.
// Reset clears the counters and loads the register defaults; store contents
// stay undefined until the first frame writes them.
module mcra_noise_estimator_top #(
    parameter int MAX_BINS = 1024
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [mcra_pkg::IDX_W-1:0] cfg_index,
    input  logic [mcra_pkg::CFG_W-1:0] cfg_data,
    mcra_in_if.sink                    spectrum,
    mcra_out_if.source                 estimate
);

    localparam int AW = $clog2(MAX_BINS);

    mcra_pkg::item_ctl_t ctl;
    mcra_pkg::result_t   result;
    logic [AW-1:0]       addr;
    logic                addr_busy;
    logic                advance;
    logic                accept;
    logic                push;

    // Stall every stage together when the output buffer is full
    always_comb
    begin
        spectrum.ready = advance && !addr_busy;
        accept         = spectrum.valid && spectrum.ready;
    end

    mcra_frame_ctrl #(
        .MAX_BINS (MAX_BINS)
    ) u_frame_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .ctl       (ctl),
        .addr      (addr)
    );

    mcra_update_pipe #(
        .MAX_BINS (MAX_BINS)
    ) u_update_pipe (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .accept    (accept),
        .ctl_in    (ctl),
        .addr_in   (addr),
        .magnitude (spectrum.magnitude),
        .addr_busy (addr_busy),
        .push      (push),
        .result    (result)
    );

    mcra_out_buf u_out_buf (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .result   (result),
        .room     (advance),
        .estimate (estimate)
    );

endmodule
